FILE: rtl/core/usc_pkg.sv
// Shared types, constants and helpers for the URI syntax checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package usc_pkg;

   // parse phase codes
   localparam logic [3:0] PH_START  = 4'd0;
   localparam logic [3:0] PH_SCHEME = 4'd1;
   localparam logic [3:0] PH_AUTH   = 4'd2;
   localparam logic [3:0] PH_HOST   = 4'd3;
   localparam logic [3:0] PH_PORT   = 4'd4;
   localparam logic [3:0] PH_IPV6   = 4'd5;
   localparam logic [3:0] PH_SLASH  = 4'd6;
   localparam logic [3:0] PH_OK     = 4'd7;
   localparam logic [3:0] PH_ERR    = 4'd8;

   // component flag bit positions
   localparam int FL_SCHEME   = 0;
   localparam int FL_USERINFO = 1;
   localparam int FL_HOST     = 2;
   localparam int FL_PORT     = 3;

   // delimiter characters
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_HASH   = 8'h23;

   // allowed-character map for codes 0..127; bit n stands for byte n
   localparam logic [127:0] ALLOWED_MAP =
      {32'h47FF_FFFE, 32'hAFFF_FFFF, 32'hAFFF_FFFA, 32'h0000_0000};

   typedef struct packed {
      logic verdict;
      logic scheme_seen;
      logic userinfo_seen;
      logic host_seen;
      logic port_seen;
   } rsp_type;

   function automatic logic char_allowed(input logic [7:0] b);
      return !b[7] && ALLOWED_MAP[b[6:0]];
   endfunction

   function automatic logic is_term(input logic [7:0] b);
      return (b == CH_SLASH) || (b == CH_QUEST) || (b == CH_HASH);
   endfunction

   // phase after a byte in scheme-or-host, starting from cur
   function automatic logic [3:0] soh_next(input logic [3:0] cur, input logic [7:0] b);
      logic [3:0] nxt;
      nxt = cur;
      if (b == CH_COLON) begin
         nxt = PH_AUTH;
      end else if (b == CH_AT) begin
         nxt = PH_HOST;
      end else if (is_term(b)) begin
         nxt = PH_OK;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/uri_syntax_checker.sv
// Top level of the URI syntax checker: input register, parser state, result register.
// Depends on usc_pkg, usc_step and usc_rsp_buf.
`default_nettype none

//  channel | direction | ports                                      | transfer
//  --------+-----------+--------------------------------------------+---------------------
//  req     | in        | req_byte_value[7:0], req_last_byte         | one URI byte
//  rsp     | out       | rsp_verdict, rsp_scheme_seen, rsp_userinfo_seen,
//          |           | rsp_host_seen, rsp_port_seen               | one verdict per URI
//
//  One byte per clock sustained while no last byte waits on a full result register; the parse
//  phase and flag registers close a loop through usc_step, which sets the rate.
//  A byte is parsed during the cycle it sits in the input register; for a last byte the
//  verdict is then loaded into the result register, from which it is valid on rsp.
//  Reset puts the parser in its start phase with no flags and empties both registers.
//  A stalled rsp only holds back a last byte; other bytes keep flowing while a verdict
//  waits.

module uri_syntax_checker
   import usc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte_value,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_verdict,
   output logic            rsp_scheme_seen,
   output logic            rsp_userinfo_seen,
   output logic            rsp_host_seen,
   output logic            rsp_port_seen
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // parser state
   logic [3:0] phase_ff, phase_in;
   logic [3:0] flags_ff, flags_in;

   logic    out_space;
   logic    step_fire;
   logic    req_fire;
   rsp_type step_result;
   rsp_type rsp_data;

   // a held byte moves on unless it is a last byte facing a full result register
   assign step_fire   = in_valid_ff && (!in_last_ff || out_space);
   assign req_ready   = !in_valid_ff || step_fire;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !step_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_last_byte;
      end
   end

   usc_step u_step (
      .phase_cur  (phase_ff),
      .flags_cur  (flags_ff),
      .byte_value (in_byte_ff),
      .last_byte  (in_last_ff),
      .phase_nxt  (phase_in),
      .flags_nxt  (flags_in),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         flags_ff <= '0;
      end else if (step_fire) begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
      end
   end

   usc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (step_fire && in_last_ff),
      .load_data (step_result),
      .space     (out_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_verdict       = rsp_data.verdict;
   assign rsp_scheme_seen   = rsp_data.scheme_seen;
   assign rsp_userinfo_seen = rsp_data.userinfo_seen;
   assign rsp_host_seen     = rsp_data.host_seen;
   assign rsp_port_seen     = rsp_data.port_seen;

   // phase never leaves the defined range
   a_phase_range: assert property (@(posedge clock)
      !reset |=> phase_ff <= PH_ERR)
      else $error("parse phase out of range");

   // a last byte leaves the parser back at its start
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_last_ff |=> phase_ff == PH_START && flags_ff == 4'd0)
      else $error("parser not restarted after verdict");

   // once ended, further non-last bytes change nothing
   a_ended_hold: assert property (@(posedge clock) disable iff (reset)
      step_fire && !in_last_ff && (phase_ff == PH_OK || phase_ff == PH_ERR)
      |=> $stable(phase_ff) && $stable(flags_ff))
      else $error("ended parser changed state");

endmodule

`default_nettype wire

FILE: rtl/core/usc_step.sv
// Per-byte next-state logic of the URI syntax checker.
// Depends on usc_pkg.
`default_nettype none

module usc_step
   import usc_pkg::*;
(
   input  wire logic [3:0] phase_cur,
   input  wire logic [3:0] flags_cur,
   input  wire logic [7:0] byte_value,
   input  wire logic       last_byte,
   output logic [3:0]      phase_nxt,
   output logic [3:0]      flags_nxt,
   output rsp_type         result
);

   logic [3:0] ph;
   logic [3:0] fl;

   always_comb begin
      ph = phase_cur;
      fl = flags_cur;
      if (phase_cur == PH_OK || phase_cur == PH_ERR) begin
         // ended early, hold until the last byte
      end else if (phase_cur == PH_SLASH) begin
         if (byte_value == CH_SLASH) begin
            fl[FL_SCHEME] = 1'b1;
            ph = PH_HOST;
         end else begin
            fl[FL_PORT] = 1'b1;
            ph = PH_OK;
         end
      end else if (!char_allowed(byte_value)) begin
         ph = PH_ERR;
      end else begin
         case (phase_cur)
            PH_START: begin
               if (byte_value == CH_SLASH) begin
                  ph = PH_OK;
               end else if (byte_value == CH_LBRACK) begin
                  ph = PH_IPV6;
                  fl[FL_HOST] = 1'b1;
               end else begin
                  fl[FL_HOST] = 1'b1;
                  ph = soh_next(PH_SCHEME, byte_value);
                  if (byte_value == CH_AT) fl[FL_USERINFO] = 1'b1;
               end
            end
            PH_SCHEME: begin
               ph = soh_next(PH_SCHEME, byte_value);
               if (byte_value == CH_AT) fl[FL_USERINFO] = 1'b1;
            end
            PH_AUTH: begin
               if (byte_value == CH_SLASH) begin
                  if (last_byte) begin
                     fl[FL_PORT] = 1'b1;
                     ph = PH_OK;
                  end else begin
                     ph = PH_SLASH;
                  end
               end else begin
                  fl[FL_PORT] = 1'b1;
                  ph = PH_PORT;
               end
            end
            PH_HOST: begin
               if (byte_value == CH_RBRACK) begin
                  ph = PH_ERR;
               end else if (byte_value == CH_AT) begin
                  fl[FL_USERINFO] = 1'b1;
               end else if (byte_value == CH_LBRACK) begin
                  ph = PH_IPV6;
               end else if (byte_value == CH_COLON) begin
                  fl[FL_PORT] = 1'b1;
                  ph = PH_PORT;
               end else if (is_term(byte_value)) begin
                  ph = PH_OK;
               end
            end
            PH_PORT: begin
               if (byte_value == CH_AT) begin
                  fl[FL_PORT] = 1'b0;
                  fl[FL_USERINFO] = 1'b1;
                  ph = PH_HOST;
               end else if (byte_value == CH_LBRACK || byte_value == CH_RBRACK ||
                            byte_value == CH_COLON) begin
                  ph = PH_ERR;
               end else if (is_term(byte_value)) begin
                  fl[FL_PORT] = 1'b1;
                  ph = PH_OK;
               end
            end
            PH_IPV6: begin
               if (byte_value == CH_RBRACK) begin
                  ph = PH_HOST;
               end else if (byte_value == CH_AT || byte_value == CH_LBRACK ||
                            is_term(byte_value)) begin
                  ph = PH_ERR;
               end
            end
            default: ph = PH_ERR;
         endcase
      end
   end

   always_comb begin
      result = '0;
      if (ph >= PH_ERR) begin
         result.verdict = 1'b1;
      end else begin
         result.scheme_seen   = fl[FL_SCHEME];
         result.userinfo_seen = fl[FL_USERINFO];
         result.host_seen     = fl[FL_HOST];
         result.port_seen     = fl[FL_PORT];
      end
      // a verdict returns the parser to its reset state
      if (last_byte) begin
         phase_nxt = PH_START;
         flags_nxt = '0;
      end else begin
         phase_nxt = ph;
         flags_nxt = fl;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/usc_rsp_buf.sv
// Result register of the URI syntax checker; holds one verdict until taken.
// Depends on usc_pkg.
`default_nettype none

module usc_rsp_buf
   import usc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_data,
   output logic         space,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // load only into a free or draining slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> space)
      else $error("result overwritten before transfer");

   // a rejected verdict never carries component flags
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.verdict |-> !data_ff.scheme_seen && !data_ff.userinfo_seen &&
                                      !data_ff.host_seen && !data_ff.port_seen)
      else $error("rejected verdict with flags set");

   // a waiting result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(data_ff))
      else $error("waiting result changed");

endmodule

`default_nettype wire
